[rtl/bounded_deque_with_positional_delete_assert.svh]
// ----------------------------------------------------------------------------
// assertion macros for the deque block
// shared property forms, clocked on clk and quiet while arst_n is low
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_WITH_POSITIONAL_DELETE_ASSERT_SVH
`define BOUNDED_DEQUE_WITH_POSITIONAL_DELETE_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define BDQ_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("deque check failed");

// consequent holds in the cycle after the antecedent
`define BDQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("deque check failed");

`endif

[rtl/bdq_pkg.sv]
// ----------------------------------------------------------------------------
// bdq_pkg
// types and constants shared by the deque cells and the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bdq_pkg;

	localparam int DEPTH    = 16;
	localparam int IDX_W    = $clog2(DEPTH);
	localparam int CNT_W    = $clog2(DEPTH + 1);
	localparam int WORD_W   = 32;
	localparam int CMD_W    = 3;
	localparam int POS_W    = 5;
	localparam int STAT_W   = 2;
	localparam int ECOUNT_W = 5;
	localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [CMD_W-1:0] {
		CMD_INS_FRONT = 3'd0,
		CMD_INS_BACK  = 3'd1,
		CMD_REM_FRONT = 3'd2,
		CMD_REM_BACK  = 3'd3,
		CMD_REM_POS   = 3'd4
	} cmd_code_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_BADPOS = 2'd3
	} status_t;

	// broadcast to every cell for one cycle
	typedef struct packed {
		logic             shift_in;  // insert at front, all cells take left neighbor
		logic             load_back; // cell at tgt loads the new word
		logic             remove;    // cells at or above tgt take right neighbor
		logic [IDX_W-1:0] tgt;
	} cell_cmd_t;

endpackage

`default_nettype wire

[rtl/bounded_deque_with_positional_delete.sv]
// ----------------------------------------------------------------------------
// bounded_deque_with_positional_delete
// ordered store of up to DEPTH signed words with front/back/positional access
// ----------------------------------------------------------------------------
// A command is taken on any clock edge where start is high; busy is always
// low, so one command can be issued every cycle. Its result appears on the
// cycle after the command, for exactly one cycle, marked by done, and must be
// captured then since the block cannot be stalled. The entries live in a row
// of DEPTH cells that all shift at once: an insert at the front moves every
// cell toward the back, a removal moves the cells at and behind the removed
// slot toward the front. Status reports ok, full (insert refused), empty
// (remove refused) or a position that is zero or past the count; a refused
// command leaves the store unchanged. entry_count and front_value show the
// state after the command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bounded_deque_with_positional_delete (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [bdq_pkg::CMD_W-1:0]     command,
	input  wire logic signed [bdq_pkg::WORD_W-1:0] value,
	input  wire logic [bdq_pkg::POS_W-1:0]     position,
	output logic                               done,
	output logic [bdq_pkg::STAT_W-1:0]         status,
	output logic [bdq_pkg::ECOUNT_W-1:0]       entry_count,
	output logic signed [bdq_pkg::WORD_W-1:0]  removed_value,
	output logic signed [bdq_pkg::WORD_W-1:0]  front_value
);
	import bdq_pkg::*;

	// control state
	logic [CNT_W-1:0]  count_q;
	logic              done_q;
	// result registers
	status_t           status_q;
	logic [WORD_W-1:0] removed_q;

	// next-state decode
	cell_cmd_t         cell_cmd;
	status_t           status_d;
	logic [CNT_W-1:0]  count_d;
	logic              take_removed;
	logic              accept;
	logic              is_empty;
	logic              is_full;
	logic              pos_bad;

	// cell row wiring
	logic [WORD_W-1:0] cell_word [DEPTH];
	logic [WORD_W-1:0] cell_sel  [DEPTH];
	logic [WORD_W-1:0] picked;

	assign busy     = 1'b0;
	assign accept   = start && !busy;
	assign is_empty = (count_q == '0);
	assign is_full  = (count_q == CNT_W'(DEPTH));
	// position zero or past the count
	assign pos_bad  = (position == '0) ||
		(CMP_W'(position) > CMP_W'(count_q));

	// command decode, one transaction per cycle
	always_comb begin
		cell_cmd     = '0;
		status_d     = ST_OK;
		count_d      = count_q;
		take_removed = 1'b0;
		case (command)
			CMD_INS_FRONT: begin
				if (is_full) begin
					status_d = ST_FULL;
				end else begin
					cell_cmd.shift_in = accept;
					count_d           = count_q + 1'b1;
				end
			end
			CMD_INS_BACK: begin
				cell_cmd.tgt = IDX_W'(count_q);
				if (is_full) begin
					status_d = ST_FULL;
				end else begin
					cell_cmd.load_back = accept;
					count_d            = count_q + 1'b1;
				end
			end
			CMD_REM_FRONT: begin
				if (is_empty) begin
					status_d = ST_EMPTY;
				end else begin
					cell_cmd.remove = accept;
					take_removed    = 1'b1;
					count_d         = count_q - 1'b1;
				end
			end
			CMD_REM_BACK: begin
				cell_cmd.tgt = IDX_W'(count_q - 1'b1);
				if (is_empty) begin
					status_d = ST_EMPTY;
				end else begin
					cell_cmd.remove = accept;
					take_removed    = 1'b1;
					count_d         = count_q - 1'b1;
				end
			end
			CMD_REM_POS: begin
				cell_cmd.tgt = IDX_W'(position - 1'b1);
				if (is_empty) begin
					status_d = ST_EMPTY;
				end else if (pos_bad) begin
					status_d = ST_BADPOS;
				end else begin
					cell_cmd.remove = accept;
					take_removed    = 1'b1;
					count_d         = count_q - 1'b1;
				end
			end
			default: begin
				// unused codes leave the store alone
				status_d = ST_OK;
			end
		endcase
	end

	// row of cells, cell 0 is the front
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WORD_W-1:0] left_w;
		logic [WORD_W-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = value;
		end else begin : g_mid_l
			assign left_w = cell_word[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = cell_word[i+1];
		end

		bdq_cell u_cell (
			.clk        (clk),
			.cmd        (cell_cmd),
			.my_idx     (IDX_W'(i)),
			.left_word  (left_w),
			.right_word (right_w),
			.ins_value  (value),
			.word       (cell_word[i]),
			.sel_word   (cell_sel[i])
		);
	end

	// only the target cell drives a nonzero selected word
	always_comb begin
		picked = '0;
		for (int i = 0; i < DEPTH; i++) begin
			picked = picked | cell_sel[i];
		end
	end

	// count and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) begin
				count_q <= count_d;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q  <= status_d;
			removed_q <= take_removed ? picked : '0;
		end
	end

	// state after the transaction is live during the done cycle
	assign done          = done_q;
	assign status        = status_q;
	assign entry_count   = ECOUNT_W'(count_q);
	assign removed_value = removed_q;
	assign front_value   = is_empty ? '0 : cell_word[0];

	`include "bounded_deque_with_positional_delete_assert.svh"

	// refused or no-op commands never change the count
	`BDQ_ASSERT_SAME(a_refused_keeps_count, done_q && (status_q != ST_OK), count_q == $past(count_q))
	// an empty report means the store really is empty
	`BDQ_ASSERT_SAME(a_empty_status_zero, done_q && (status_q == ST_EMPTY), count_q == '0)
	// a removal that succeeds drops exactly one entry
	`BDQ_ASSERT_NEXT(a_remove_drops_one, accept && cell_cmd.remove, count_q == ($past(count_q) - 1'b1))
	// the count never exceeds the store depth
	`BDQ_ASSERT_SAME(a_count_bounded, 1'b1, count_q <= CNT_W'(DEPTH))

endmodule

`default_nettype wire

[rtl/bdq_cell.sv]
// ----------------------------------------------------------------------------
// bdq_cell
// one storage slot of the deque, shifts toward either neighbor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bdq_cell (
	input  wire logic                         clk,
	input  wire bdq_pkg::cell_cmd_t           cmd,
	input  wire logic [bdq_pkg::IDX_W-1:0]    my_idx,
	input  wire logic [bdq_pkg::WORD_W-1:0]   left_word,
	input  wire logic [bdq_pkg::WORD_W-1:0]   right_word,
	input  wire logic [bdq_pkg::WORD_W-1:0]   ins_value,
	output logic      [bdq_pkg::WORD_W-1:0]   word,
	output logic      [bdq_pkg::WORD_W-1:0]   sel_word
);
	import bdq_pkg::*;

	logic [WORD_W-1:0] word_q;
	logic              hit;

	assign hit      = (my_idx == cmd.tgt);
	assign word     = word_q;
	assign sel_word = hit ? word_q : '0;

	// payload only, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.shift_in) begin
			word_q <= left_word;
		end else if (cmd.load_back && hit) begin
			word_q <= ins_value;
		end else if (cmd.remove && (my_idx >= cmd.tgt)) begin
			word_q <= right_word;
		end
	end

endmodule

`default_nettype wire
